FILE: hw/rtl/assert_macros.svh
// Assertion helpers, sampled on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/wsd_pkg.sv
package wsd_pkg;

	typedef enum logic [2:0] {
		KIND_BYTE       = 3'd0,
		KIND_EMPTY      = 3'd1,
		KIND_PONG       = 3'd2,
		KIND_EMPTY_PONG = 3'd3,
		KIND_CLOSE      = 3'd4,
		KIND_ERROR      = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE        = 3'd0,
		ERR_LEN64       = 3'd1,
		ERR_CTRL_LONG   = 3'd2,
		ERR_FRAME_LEN   = 3'd3,
		ERR_PREFIX      = 3'd4,
		ERR_BODY_LARGE  = 3'd5
	} err_t;

	localparam logic [3:0] OPC_CLOSE = 4'd8;
	localparam logic [3:0] OPC_PING  = 4'd9;
	localparam logic [3:0] OPC_PONG  = 4'd10;

	localparam logic [6:0] LEN_FORM_16 = 7'd126;
	localparam logic [6:0] LEN_FORM_64 = 7'd127;
	localparam logic [31:0] CTRL_MAX_LEN = 32'd125;
	localparam logic [30:0] MAX_MSG_RESET = 31'd1048576;

endpackage

FILE: hw/rtl/wsd_rx_if.sv
interface wsd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: hw/rtl/wsd_res_if.sv
interface wsd_res_if;
	logic          valid;
	logic          ready;
	wsd_pkg::kind_t kind;
	logic [7:0]    out_byte;
	logic          last;
	wsd_pkg::err_t error_code;

	modport source (output valid, output kind, output out_byte, output last,
		output error_code, input ready);
	modport sink   (input valid, input kind, input out_byte, input last,
		input error_code, output ready);
endinterface

FILE: hw/rtl/websocket_frame_deframer.sv
// channel | direction | payload
// rx      | in        | rx_byte[7:0]
// res     | out       | kind[2:0], out_byte[7:0], last, error_code[2:0]
// cfg     | in        | cfg_wdata[30:0] (max_message_bytes), written on cfg_we
//
// One byte per cycle while the result is not stalled: a byte is held in the input
// register, then the header/unmask logic writes the result register.
// Reset clears the parser to the first header byte, max_message_bytes to 1048576.
// A stalled result holds the input register; rx.ready drops only then.
// After an error or a close frame, bytes are taken and dropped until reset.
`include "assert_macros.svh"

module websocket_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	wsd_rx_if.sink      rx,
	wsd_res_if.source   res,
	input  logic        cfg_we,
	input  logic [30:0] cfg_wdata
);
	import wsd_pkg::*;

	typedef enum logic [2:0] {
		PH_HDR0 = 3'd0,
		PH_HDR1 = 3'd1,
		PH_HDRX = 3'd2,
		PH_CTRL = 3'd3,
		PH_BODY = 3'd4,
		PH_HALT = 3'd5
	} phase_t;

	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        out_free, advance;

	logic [30:0] max_q;
	phase_t      phase_q, n_phase;
	logic [3:0]  hc_q, n_hc;
	logic [3:0]  op_q, n_op;
	logic        masked_q, n_masked;
	logic [6:0]  lf_q, n_lf;
	logic [31:0] pl_q, n_pl;
	logic [31:0] idx_q, n_idx;
	logic [31:0] key_q, n_key;
	logic [31:0] bl_q, n_bl;

	logic        res_valid_q;
	kind_t       res_kind_q;
	logic [7:0]  res_byte_q;
	logic        res_last_q;
	err_t        res_code_q;

	logic        emit, fin;
	kind_t       e_kind;
	logic [7:0]  e_byte;
	logic        e_last;
	err_t        e_code;
	logic [7:0]  key_byte, d;
	logic [3:0]  ext, need;
	logic [31:0] nb, rel, max32;

	assign out_free = !res_valid_q || res.ready;
	assign advance  = v_s1 && out_free;
	assign rx.ready = !v_s1 || out_free;

	assign res.valid      = res_valid_q;
	assign res.kind       = res_kind_q;
	assign res.out_byte   = res_byte_q;
	assign res.last       = res_last_q;
	assign res.error_code = res_code_q;

	assign max32 = {1'b0, max_q};

	always_comb begin
		case (idx_q[1:0])
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
		d = masked_q ? (byte_s1 ^ key_byte) : byte_s1;
		if (lf_q == LEN_FORM_16) begin
			ext = 4'd2;
		end else if (lf_q == LEN_FORM_64) begin
			ext = 4'd8;
		end else begin
			ext = 4'd0;
		end
		need = ext + (masked_q ? 4'd4 : 4'd0);
		nb   = {bl_q[23:0], d};
		rel  = idx_q - 32'd4;

		n_phase  = phase_q;
		n_hc     = hc_q;
		n_op     = op_q;
		n_masked = masked_q;
		n_lf     = lf_q;
		n_pl     = pl_q;
		n_idx    = idx_q;
		n_key    = key_q;
		n_bl     = bl_q;
		emit     = 1'b0;
		fin      = 1'b0;
		e_kind   = KIND_BYTE;
		e_byte   = 8'd0;
		e_last   = 1'b0;
		e_code   = ERR_NONE;

		case (phase_q)
			PH_HDR0: begin
				n_op    = byte_s1[3:0];
				n_phase = PH_HDR1;
			end
			PH_HDR1: begin
				n_masked = byte_s1[7];
				n_lf     = byte_s1[6:0];
				n_pl     = (byte_s1[6:0] < LEN_FORM_16) ? {25'd0, byte_s1[6:0]} : 32'd0;
				n_hc     = 4'd0;
				n_bl     = 32'd0;
				n_phase  = PH_HDRX;
				fin      = (byte_s1[6:0] < LEN_FORM_16) && !byte_s1[7];
			end
			PH_HDRX: begin
				if (hc_q < ext) begin
					if (lf_q == LEN_FORM_64 && hc_q < 4'd4) begin
						n_bl = bl_q | {24'd0, byte_s1};
					end else begin
						n_pl = {pl_q[23:0], byte_s1};
					end
				end else begin
					n_key = {key_q[23:0], byte_s1};
				end
				n_hc = hc_q + 4'd1;
				fin  = (n_hc >= need);
			end
			PH_CTRL: begin
				n_idx = idx_q + 32'd1;
				if (op_q == OPC_PING) begin
					emit   = 1'b1;
					e_kind = KIND_PONG;
					e_byte = d;
					e_last = (n_idx >= pl_q);
				end
				if (n_idx >= pl_q) begin
					n_phase = PH_HDR0;
				end
			end
			PH_BODY: begin
				n_idx = idx_q + 32'd1;
				if (n_idx >= pl_q) begin
					n_phase = PH_HDR0;
				end
				if (idx_q < 32'd4) begin
					n_bl = nb;
					if (idx_q == 32'd3) begin
						if (nb > pl_q - 32'd4) begin
							n_phase = PH_HALT;
							emit    = 1'b1;
							e_kind  = KIND_ERROR;
							e_code  = ERR_PREFIX;
						end else if (nb > max32) begin
							n_phase = PH_HALT;
							emit    = 1'b1;
							e_kind  = KIND_ERROR;
							e_code  = ERR_BODY_LARGE;
						end else if (nb == 32'd0) begin
							emit   = 1'b1;
							e_kind = KIND_EMPTY;
							e_last = 1'b1;
						end
					end
				end else if (rel < bl_q) begin
					emit   = 1'b1;
					e_kind = KIND_BYTE;
					e_byte = d;
					e_last = (rel == bl_q - 32'd1);
				end
			end
			default: begin
			end
		endcase

		if (fin) begin
			if (n_lf == LEN_FORM_64 && n_bl != 32'd0) begin
				n_phase = PH_HALT;
				emit    = 1'b1;
				e_kind  = KIND_ERROR;
				e_code  = ERR_LEN64;
			end else if (n_op == OPC_CLOSE) begin
				n_phase = PH_HALT;
				emit    = 1'b1;
				e_kind  = KIND_CLOSE;
			end else begin
				n_idx = 32'd0;
				n_bl  = 32'd0;
				if (n_op == OPC_PING || n_op == OPC_PONG) begin
					if (n_pl > CTRL_MAX_LEN) begin
						n_phase = PH_HALT;
						emit    = 1'b1;
						e_kind  = KIND_ERROR;
						e_code  = ERR_CTRL_LONG;
					end else if (n_pl == 32'd0) begin
						n_phase = PH_HDR0;
						if (n_op == OPC_PING) begin
							emit   = 1'b1;
							e_kind = KIND_EMPTY_PONG;
							e_last = 1'b1;
						end
					end else begin
						n_phase = PH_CTRL;
					end
				end else if (n_pl < 32'd4 || n_pl - 32'd4 > max32) begin
					n_phase = PH_HALT;
					emit    = 1'b1;
					e_kind  = KIND_ERROR;
					e_code  = ERR_FRAME_LEN;
				end else begin
					n_phase = PH_BODY;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			max_q       <= MAX_MSG_RESET;
			phase_q     <= PH_HDR0;
			hc_q        <= 4'd0;
			op_q        <= 4'd0;
			masked_q    <= 1'b0;
			lf_q        <= 7'd0;
			pl_q        <= 32'd0;
			idx_q       <= 32'd0;
			key_q       <= 32'd0;
			bl_q        <= 32'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (rx.ready) begin
				v_s1 <= rx.valid;
			end
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (advance) begin
				phase_q  <= n_phase;
				hc_q     <= n_hc;
				op_q     <= n_op;
				masked_q <= n_masked;
				lf_q     <= n_lf;
				pl_q     <= n_pl;
				idx_q    <= n_idx;
				key_q    <= n_key;
				bl_q     <= n_bl;
			end
			if (out_free) begin
				res_valid_q <= advance && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
		if (advance && emit) begin
			res_kind_q <= e_kind;
			res_byte_q <= e_byte;
			res_last_q <= e_last;
			res_code_q <= e_code;
		end
	end

	`ASSERT_NEXT(halt_no_result, phase_q == PH_HALT && out_free, !res_valid_q)
	`ASSERT_IMPLIES(err_code_match, res_valid_q, (res_kind_q == KIND_ERROR) == (res_code_q != ERR_NONE))
	`ASSERT_IMPLIES(err_halts, res_valid_q && res_kind_q == KIND_ERROR, phase_q == PH_HALT)
	`ASSERT_IMPLIES(hdr_count_range, phase_q == PH_HDRX, hc_q < 4'd12)

endmodule

FILE: bench/wsd_checker.sv
module wsd_checker (
	input  logic        clk,
	input  logic        arst_n,
	wsd_rx_if           rx,
	wsd_res_if          res,
	input  logic        cfg_we,
	input  logic [30:0] cfg_wdata,
	output int          mismatches,
	output int          outstanding,
	output int          delivered
);
	timeunit 1ns;
	timeprecision 1ps;
	import wsd_pkg::*;

	typedef enum logic [2:0] {
		PH_HDR0, PH_HDR1, PH_HDRX, PH_CTRL, PH_BODY, PH_HALT
	} parse_phase_t;

	typedef struct {
		kind_t      kind;
		logic [7:0] out_byte;
		logic       last;
		err_t       error_code;
	} frame_event_t;

	frame_event_t pending_events[$];

	parse_phase_t phase;
	logic [3:0]   hdr_cnt;
	logic [3:0]   opcode;
	logic         masked;
	logic [6:0]   len_form;
	logic [31:0]  pay_len;
	logic [31:0]  pay_idx;
	logic [31:0]  xor_key;
	logic [31:0]  msg_len;
	logic [30:0]  max_msg;

	initial begin
		mismatches = 0;
		outstanding = 0;
		delivered = 0;
	end

	function automatic int ext_len();
		if (len_form == LEN_FORM_16) return 2;
		if (len_form == LEN_FORM_64) return 8;
		return 0;
	endfunction

	function automatic logic [7:0] unmasked(input logic [7:0] b);
		if (!masked) return b;
		return b ^ xor_key[8 * (3 - pay_idx[1:0]) +: 8];
	endfunction

	task automatic post(input kind_t k, input logic [7:0] d, input logic l, input err_t e);
		frame_event_t ev;
		ev.kind = k;
		ev.out_byte = d;
		ev.last = l;
		ev.error_code = e;
		pending_events.push_back(ev);
	endtask

	task automatic halt_with(input err_t e);
		phase = PH_HALT;
		post(KIND_ERROR, 8'h00, 1'b0, e);
	endtask

	task automatic close_header();
		if (len_form == LEN_FORM_64 && msg_len != 32'd0) begin
			halt_with(ERR_LEN64);
			return;
		end
		if (opcode == OPC_CLOSE) begin
			phase = PH_HALT;
			post(KIND_CLOSE, 8'h00, 1'b0, ERR_NONE);
			return;
		end
		pay_idx = 32'd0;
		msg_len = 32'd0;
		if (opcode == OPC_PING || opcode == OPC_PONG) begin
			if (pay_len > CTRL_MAX_LEN) begin
				halt_with(ERR_CTRL_LONG);
			end else if (pay_len == 32'd0) begin
				phase = PH_HDR0;
				if (opcode == OPC_PING)
					post(KIND_EMPTY_PONG, 8'h00, 1'b1, ERR_NONE);
			end else begin
				phase = PH_CTRL;
			end
		end else if (pay_len < 32'd4 || pay_len - 32'd4 > {1'b0, max_msg}) begin
			halt_with(ERR_FRAME_LEN);
		end else begin
			phase = PH_BODY;
		end
	endtask

	task automatic parse_rx_byte(input logic [7:0] b);
		int need;
		logic [7:0] d;
		case (phase)
			PH_HDR0: begin
				opcode = b[3:0];
				phase = PH_HDR1;
			end
			PH_HDR1: begin
				masked = b[7];
				len_form = b[6:0];
				pay_len = (b[6:0] < LEN_FORM_16) ? {25'd0, b[6:0]} : 32'd0;
				hdr_cnt = 4'd0;
				msg_len = 32'd0;
				if (ext_len() + (masked ? 4 : 0) == 0)
					close_header();
				else
					phase = PH_HDRX;
			end
			PH_HDRX: begin
				need = ext_len() + (masked ? 4 : 0);
				if (hdr_cnt < ext_len()) begin
					if (len_form == LEN_FORM_64 && hdr_cnt < 4'd4)
						msg_len = msg_len | {24'd0, b};
					else
						pay_len = {pay_len[23:0], b};
				end else begin
					xor_key = {xor_key[23:0], b};
				end
				hdr_cnt = hdr_cnt + 4'd1;
				if (hdr_cnt >= need)
					close_header();
			end
			PH_CTRL: begin
				d = unmasked(b);
				pay_idx = pay_idx + 32'd1;
				if (opcode == OPC_PING)
					post(KIND_PONG, d, pay_idx >= pay_len, ERR_NONE);
				if (pay_idx >= pay_len)
					phase = PH_HDR0;
			end
			PH_BODY: begin
				d = unmasked(b);
				if (pay_idx < 32'd4) begin
					msg_len = {msg_len[23:0], d};
					if (pay_idx == 32'd3) begin
						if (msg_len > pay_len - 32'd4) begin
							halt_with(ERR_PREFIX);
							return;
						end
						if (msg_len > {1'b0, max_msg}) begin
							halt_with(ERR_BODY_LARGE);
							return;
						end
						if (msg_len == 32'd0)
							post(KIND_EMPTY, 8'h00, 1'b1, ERR_NONE);
					end
				end else if (pay_idx - 32'd4 < msg_len) begin
					post(KIND_BYTE, d, pay_idx - 32'd4 == msg_len - 32'd1, ERR_NONE);
				end
				pay_idx = pay_idx + 32'd1;
				if (pay_idx >= pay_len)
					phase = PH_HDR0;
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_event_t got;
		frame_event_t want;
		if (!arst_n) begin
			phase = PH_HDR0;
			hdr_cnt = 4'd0;
			opcode = 4'd0;
			masked = 1'b0;
			len_form = 7'd0;
			pay_len = 32'd0;
			pay_idx = 32'd0;
			xor_key = 32'd0;
			msg_len = 32'd0;
			max_msg = MAX_MSG_RESET;
			pending_events.delete();
			outstanding = 0;
		end else begin
			if (cfg_we)
				max_msg = cfg_wdata;
			if (res.valid && res.ready) begin
				delivered++;
				got.kind = res.kind;
				got.out_byte = res.out_byte;
				got.last = res.last;
				got.error_code = res.error_code;
				if (pending_events.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result kind %0d byte %02h last %0b err %0d",
							$realtime, got.kind, got.out_byte, got.last, got.error_code);
				end else begin
					want = pending_events.pop_front();
					if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
							got.last !== want.last || got.error_code !== want.error_code) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: mismatch: expected kind %0d byte %02h last %0b err %0d,",
								" got kind %0d byte %02h last %0b err %0d"}, $realtime,
								want.kind, want.out_byte, want.last, want.error_code,
								got.kind, got.out_byte, got.last, got.error_code);
					end
				end
			end
			if (rx.valid && rx.ready)
				parse_rx_byte(rx.rx_byte);
			outstanding = pending_events.size();
		end
	end
endmodule

FILE: bench/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import wsd_pkg::*;

	localparam int FORM_7  = 0;
	localparam int FORM_16 = 1;
	localparam int FORM_64 = 2;
	localparam int HOLD_CYCLES = 300;

	typedef enum {
		END_CLOSE, END_LEN64, END_CTRL_LONG, END_FRAME_LEN, END_PREFIX
	} finale_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [30:0] cfg_wdata;
	int          mismatches;
	int          outstanding;
	int          delivered;

	wsd_rx_if  rx();
	wsd_res_if res();

	websocket_frame_deframer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	wsd_checker i_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx          (rx),
		.res         (res),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.delivered   (delivered)
	);

	logic [7:0]  byte_q[$];
	logic [7:0]  plain_q[$];
	logic [30:0] cur_max;
	bit          src_calm;
	bit          sink_calm;
	bit          hold_req;
	int          frames;
	int          bytes_sent;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int n;
		res.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				n = HOLD_CYCLES;
			end else begin
				n = sink_calm ? 0 : $urandom_range(0, 10);
			end
			if (n != 0) begin
				res.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid);
		end
	end

	function automatic int pick_form(input logic [31:0] plen);
		if (plen <= 125) begin
			if ($urandom_range(0, 9) < 7) return FORM_7;
			return $urandom_range(0, 1) ? FORM_16 : FORM_64;
		end
		if (plen <= 65535) return $urandom_range(0, 1) ? FORM_16 : FORM_64;
		return FORM_64;
	endfunction

	function automatic logic [3:0] data_opcode();
		logic [3:0] opc;
		do opc = 4'($urandom_range(0, 15));
		while (opc == OPC_CLOSE || opc == OPC_PING || opc == OPC_PONG);
		return opc;
	endfunction

	task automatic push_header(input logic [3:0] opc, input bit masked, input logic [31:0] plen,
			input int form, input logic [31:0] key, input logic [31:0] high_word);
		logic [3:0] flags;
		flags = 4'($urandom_range(0, 15));
		frames++;
		byte_q.push_back({flags, opc});
		case (form)
			FORM_7: byte_q.push_back({masked, plen[6:0]});
			FORM_16: begin
				byte_q.push_back({masked, LEN_FORM_16});
				byte_q.push_back(plen[15:8]);
				byte_q.push_back(plen[7:0]);
			end
			default: begin
				byte_q.push_back({masked, LEN_FORM_64});
				for (int i = 3; i >= 0; i--) byte_q.push_back(high_word[8*i +: 8]);
				for (int i = 3; i >= 0; i--) byte_q.push_back(plen[8*i +: 8]);
			end
		endcase
		if (masked)
			for (int i = 3; i >= 0; i--) byte_q.push_back(key[8*i +: 8]);
	endtask

	task automatic push_frame(input logic [3:0] opc);
		bit masked;
		logic [31:0] key;
		logic [31:0] plen;
		masked = 1'($urandom_range(0, 1));
		key = $urandom;
		plen = 32'(plain_q.size());
		push_header(opc, masked, plen, pick_form(plen), key, 32'd0);
		for (int i = 0; i < plain_q.size(); i++)
			byte_q.push_back(masked ? plain_q[i] ^ key[8*(3 - (i % 4)) +: 8] : plain_q[i]);
	endtask

	task automatic gen_data_frame();
		logic [31:0] body;
		logic [31:0] trail;
		body = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 20);
		if (body > {1'b0, cur_max}) body = {1'b0, cur_max};
		trail = $urandom_range(0, 3);
		if (body + trail > {1'b0, cur_max}) trail = {1'b0, cur_max} - body;
		plain_q.delete();
		for (int i = 3; i >= 0; i--) plain_q.push_back(body[8*i +: 8]);
		repeat (body + trail) plain_q.push_back(8'($urandom));
		push_frame(data_opcode());
	endtask

	task automatic gen_ctrl_frame(input logic [3:0] opc);
		int len;
		len = ($urandom_range(0, 29) == 0) ? 125 : $urandom_range(0, 10);
		plain_q.delete();
		repeat (len) plain_q.push_back(8'($urandom));
		push_frame(opc);
	endtask

	task automatic send_all();
		int gap;
		while (byte_q.size() != 0) begin
			gap = src_calm ? 0 : $urandom_range(0, 10);
			if (gap != 0) begin
				rx.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rx.valid <= 1'b1;
			rx.rx_byte <= byte_q.pop_front();
			do @(posedge clk); while (!rx.ready);
			bytes_sent++;
		end
		rx.valid <= 1'b0;
	endtask

	task automatic random_traffic(input int n);
		int pick;
		while (byte_q.size() < n) begin
			pick = $urandom_range(0, 19);
			if (pick < 11) gen_data_frame();
			else if (pick < 16) gen_ctrl_frame(OPC_PING);
			else gen_ctrl_frame(OPC_PONG);
		end
		send_all();
	endtask

	// results drain, then a few cycles for bytes that produce nothing
	task automatic settle();
		repeat (2) @(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_max(input logic [30:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_max = v;
	endtask

	initial begin
		finale_t finale;
		logic [31:0] plen;
		logic [31:0] hw;
		logic [31:0] x;
		logic [31:0] prefix;
		arst_n = 1'b0;
		rx.valid <= 1'b0;
		rx.rx_byte <= 8'h00;
		cfg_we <= 1'b0;
		cfg_wdata <= 31'd0;
		cur_max = MAX_MSG_RESET;
		hold_req = 1'b0;
		src_calm = 1'b0;
		sink_calm = 1'b0;
		frames = 0;
		bytes_sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty ping, empty pong, empty message with a trailing byte,
		// masked two-byte ping in 16-bit form, one-byte message in 64-bit form
		byte_q = {8'h89, 8'h00, 8'h0A, 8'h00,
			8'h82, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF,
			8'h89, 8'hFE, 8'h00, 8'h02, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h5A,
			8'h01, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h05,
			8'h00, 8'h00, 8'h00, 8'h01, 8'hFF};
		frames += 5;
		send_all();
		settle();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_max(31'd0);
				1: write_max(31'h7FFF_FFFF);
				2: write_max(31'd3);
				3: write_max(31'($urandom_range(1, 40)));
				4: write_max(MAX_MSG_RESET);
				default: write_max(31'($urandom));
			endcase
			src_calm = (ph == 2);
			sink_calm = (ph == 4);
			if (ph == 1) hold_req = 1'b1;
			random_traffic(100);
			settle();
		end
		src_calm = 1'b0;
		sink_calm = 1'b0;

		finale = finale_t'($urandom_range(0, 4));
		case (finale)
			END_CLOSE: push_header(OPC_CLOSE, 1'($urandom_range(0, 1)), $urandom_range(0, 5),
				FORM_7, $urandom, 32'd0);
			END_LEN64: begin
				hw = $urandom | (32'd1 << $urandom_range(0, 31));
				push_header(data_opcode(), 1'($urandom_range(0, 1)), 32'd5, FORM_64,
					$urandom, hw);
			end
			END_CTRL_LONG: push_header($urandom_range(0, 1) ? OPC_PING : OPC_PONG,
				1'($urandom_range(0, 1)), $urandom_range(126, 65535),
				$urandom_range(0, 1) ? FORM_16 : FORM_64, $urandom, 32'd0);
			END_FRAME_LEN: begin
				if ($urandom_range(0, 1))
					plen = $urandom_range(0, 3);
				else
					plen = {1'b0, cur_max} + 32'd5 + $urandom_range(0, 100);
				push_header(data_opcode(), 1'($urandom_range(0, 1)), plen, pick_form(plen),
					$urandom, 32'd0);
			end
			default: begin
				x = $urandom_range(0, (cur_max < 8) ? cur_max : 8);
				prefix = x + 32'd1 + $urandom_range(0, 1000);
				plain_q.delete();
				for (int i = 3; i >= 0; i--) plain_q.push_back(prefix[8*i +: 8]);
				repeat (x) plain_q.push_back(8'($urandom));
				push_frame(data_opcode());
			end
		endcase
		// everything after the halt must be swallowed
		repeat (20) byte_q.push_back(8'($urandom));
		send_all();
		settle();
		repeat (10) @(posedge clk);

		$display("Covered %0d frames, %0d bytes and %0d results over six length limits,",
			frames, bytes_sent, delivered);
		$display("with a receiver hold-off; run closed by %s (%0d results never arrived).",
			finale.name(), outstanding);
		if (mismatches == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

FILE: websocket_frame_deframer.f
+incdir+hw/rtl
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_rx_if.sv
hw/rtl/wsd_res_if.sv
hw/rtl/websocket_frame_deframer.sv
bench/wsd_checker.sv
bench/tb_top.sv
